// ----- sv/pfc_pkg.sv -----
package pfc_pkg;

  localparam logic [2:0] FMT_A8       = 3'd0;
  localparam logic [2:0] FMT_I8       = 3'd1;
  localparam logic [2:0] FMT_IA88     = 3'd2;
  localparam logic [2:0] FMT_RGB888   = 3'd3;
  localparam logic [2:0] FMT_RGBA8888 = 3'd4;

  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
  localparam logic [1:0] REG_WIDTH_PIXELS  = 2'd2;
  localparam logic [1:0] REG_IN_ROW_BYTES  = 2'd3;

  localparam int MAX_ROW_PIXELS = 65536;
  localparam int PIX_W          = $clog2(MAX_ROW_PIXELS + 1);
  localparam int STRIDE_MAX     = 262144;
  localparam int POS_W          = $clog2(STRIDE_MAX);

  // luma = (299R + 587G + 114B + 500) / 1000, divide done by reciprocal
  localparam int LUMA_R      = 299;
  localparam int LUMA_G      = 587;
  localparam int LUMA_B      = 114;
  localparam int LUMA_ROUND  = 500;
  localparam int LUMA_DIV    = 1000;
  localparam int LUMA_SHIFT  = 28;
  localparam int LUMA_RECIP  = (2 ** LUMA_SHIFT + LUMA_DIV - 1) / LUMA_DIV;
  localparam int SUM_W       = 18;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  typedef struct packed {
    logic [2:0]  src_fmt;
    logic [2:0]  dst_fmt;
    logic [16:0] width;
    logic [18:0] stride;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic [2:0] byte_count;
    logic       row_end;
  } result_t;

  // one gathered pixel handed from front to back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] src;
    logic [2:0] dst;
    logic       row_end;
  } rec_t;

  function automatic logic [2:0] fmt_code(input logic [2:0] f);
    return (f > FMT_RGBA8888) ? FMT_RGBA8888 : f;
  endfunction

  function automatic logic [2:0] fmt_bytes(input logic [2:0] f);
    logic [2:0] n;
    unique case (f)
      FMT_A8, FMT_I8: n = 3'd1;
      FMT_IA88:       n = 3'd2;
      FMT_RGB888:     n = 3'd3;
      default:        n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [3:0][7:0] convert(input logic [2:0] src, input logic [2:0] dst,
                                              input logic [3:0][7:0] b, input logic [7:0] y);
    logic [3:0][7:0] o;
    o = '0;
    if (src == dst || (src <= FMT_I8 && dst <= FMT_I8)) begin
      o = b;
    end else begin
      unique case ({src, dst})
        {FMT_A8, FMT_IA88}:         begin o[0] = ALPHA_OPAQUE; o[1] = b[0]; end
        {FMT_A8, FMT_RGBA8888}:     o[3] = b[0];
        {FMT_I8, FMT_IA88}:         begin o[0] = b[0]; o[1] = ALPHA_OPAQUE; end
        {FMT_I8, FMT_RGB888}:       begin o[0] = b[0]; o[1] = b[0]; o[2] = b[0]; end
        {FMT_I8, FMT_RGBA8888}: begin
          o[0] = b[0]; o[1] = b[0]; o[2] = b[0]; o[3] = ALPHA_OPAQUE;
        end
        {FMT_IA88, FMT_A8}:         o[0] = b[1];
        {FMT_IA88, FMT_I8}:         o[0] = b[0];
        {FMT_IA88, FMT_RGB888}:     begin o[0] = b[0]; o[1] = b[0]; o[2] = b[0]; end
        {FMT_IA88, FMT_RGBA8888}: begin
          o[0] = b[0]; o[1] = b[0]; o[2] = b[0]; o[3] = b[1];
        end
        {FMT_RGB888, FMT_I8}:       o[0] = y;
        {FMT_RGB888, FMT_IA88}:     begin o[0] = y; o[1] = ALPHA_OPAQUE; end
        {FMT_RGB888, FMT_RGBA8888}: begin
          o[0] = b[0]; o[1] = b[1]; o[2] = b[2]; o[3] = ALPHA_OPAQUE;
        end
        {FMT_RGBA8888, FMT_A8}:     o[0] = b[3];
        {FMT_RGBA8888, FMT_I8}:     o[0] = y;
        {FMT_RGBA8888, FMT_IA88}:   begin o[0] = y; o[1] = b[3]; end
        {FMT_RGBA8888, FMT_RGB888}: begin o[0] = b[0]; o[1] = b[1]; o[2] = b[2]; end
        default:                    o = '0;
      endcase
    end
    return o;
  endfunction

endpackage

// ----- sv/pfc_front.sv -----
module pfc_front (
  input  logic              clk,
  input  logic              rst,
  input  pfc_pkg::cfg_t     cfg,
  input  logic              push,
  input  pfc_pkg::in_item_t pixel_byte,
  input  logic              q_full,
  output logic              q_push,
  output pfc_pkg::rec_t     q_rec
);
  import pfc_pkg::*;

  logic [POS_W-1:0] row_pos, row_pos_next, pos_cur;
  logic [PIX_W-1:0] pix_cnt, pix_cnt_next, pix_cur, width_eff;
  logic [1:0]       ch_pos, ch_pos_next, ch_cur;
  logic [23:0]      held, held_next, held_cur;
  logic [18:0]      stride_eff;
  logic [2:0]       src, dst, need;
  logic             accept, active, finish, row_done;
  logic [3:0][7:0]  b;

  always_comb begin
    src = fmt_code(cfg.src_fmt);
    dst = fmt_code(cfg.dst_fmt);
    width_eff = (32'(cfg.width) > 32'(MAX_ROW_PIXELS)) ? PIX_W'(MAX_ROW_PIXELS)
                                                       : PIX_W'(cfg.width);
    if (cfg.stride == 19'd0)
      stride_eff = 19'd1;
    else if (32'(cfg.stride) > 32'(STRIDE_MAX))
      stride_eff = 19'(STRIDE_MAX);
    else
      stride_eff = cfg.stride;

    // image start clears position state before the byte is taken
    pos_cur  = pixel_byte.image_start ? '0 : row_pos;
    pix_cur  = pixel_byte.image_start ? '0 : pix_cnt;
    ch_cur   = pixel_byte.image_start ? '0 : ch_pos;
    held_cur = pixel_byte.image_start ? '0 : held;

    accept   = push && !q_full;
    active   = pix_cur < width_eff;
    need     = fmt_bytes(src);
    finish   = active && (({1'b0, ch_cur} + 3'd1) >= need);
    row_done = ({1'b0, pos_cur} + 19'd1) >= stride_eff;

    b    = {8'd0, held_cur};
    b[ch_cur] = pixel_byte.data_byte;

    held_next = held_cur;
    unique case (ch_cur)
      2'd0: held_next[7:0]   = pixel_byte.data_byte;
      2'd1: held_next[15:8]  = pixel_byte.data_byte;
      2'd2: held_next[23:16] = pixel_byte.data_byte;
      2'd3: held_next        = held_cur;
    endcase

    pix_cnt_next = pix_cur;
    ch_pos_next  = ch_cur;
    if (finish) begin
      pix_cnt_next = pix_cur + 1'b1;
      ch_pos_next  = '0;
      held_next    = '0;
    end else if (active) begin
      ch_pos_next  = ch_cur + 2'd1;
    end else begin
      held_next    = held_cur;
    end

    row_pos_next = pos_cur + 1'b1;
    if (row_done) begin
      row_pos_next = '0;
      pix_cnt_next = '0;
      ch_pos_next  = '0;
      held_next    = '0;
    end

    q_push        = accept && finish;
    q_rec.b0      = b[0];
    q_rec.b1      = b[1];
    q_rec.b2      = b[2];
    q_rec.b3      = b[3];
    q_rec.src     = src;
    q_rec.dst     = dst;
    q_rec.row_end = (pix_cur + 1'b1) == width_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      pix_cnt <= '0;
      ch_pos  <= '0;
      held    <= '0;
    end else if (accept) begin
      row_pos <= row_pos_next;
      pix_cnt <= pix_cnt_next;
      ch_pos  <= ch_pos_next;
      held    <= held_next;
    end
  end

endmodule

// ----- sv/pfc_queue.sv -----
module pfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfc_pkg::rec_t wr_rec,
  input  logic          pop,
  output pfc_pkg::rec_t rd_rec,
  output logic          full,
  output logic          empty
);
  import pfc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rec_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full   = count == CNT_W'(QUEUE_DEPTH);
  assign empty  = count == '0;
  assign do_wr  = push && !full;
  assign do_rd  = pop && !empty;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd)
        count <= count + 1'b1;
      else if (do_rd && !do_wr)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_rec;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("pixel pushed into full queue");

endmodule

// ----- sv/pfc_back.sv -----
module pfc_back (
  input  logic             clk,
  input  logic             rst,
  input  pfc_pkg::rec_t    q_rec,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output pfc_pkg::result_t pixel
);
  import pfc_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  // stage 1: weighted sum, stage 2: reciprocal divide, then output queue
  logic              v1, v2;
  rec_t              r1, r2;
  logic [SUM_W-1:0]  sum, sum1;
  logic [PROD_W-1:0] prod;
  logic [7:0]        luma2;
  logic [3:0][7:0]   conv;
  logic [2:0]        n_out;
  result_t           res;

  result_t           mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W:0]    in_use;
  logic              do_rd;

  // issue only when the output queue has room for everything in flight
  assign in_use = {1'b0, count} + (CNT_W+1)'(v1) + (CNT_W+1)'(v2);
  assign q_pop  = !q_empty && (in_use < (CNT_W+1)'(OUT_DEPTH));

  assign sum = SUM_W'(q_rec.b0) * SUM_W'(LUMA_R) + SUM_W'(q_rec.b1) * SUM_W'(LUMA_G)
             + SUM_W'(q_rec.b2) * SUM_W'(LUMA_B) + SUM_W'(LUMA_ROUND);
  assign prod = PROD_W'(sum1) * PROD_W'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    r1    <= q_rec;
    sum1  <= sum;
    r2    <= r1;
    luma2 <= prod[LUMA_SHIFT+7:LUMA_SHIFT];
  end

  always_comb begin
    conv  = convert(r2.src, r2.dst, {r2.b3, r2.b2, r2.b1, r2.b0}, luma2);
    n_out = fmt_bytes(r2.dst);
    res.chan0      = conv[0];
    res.chan1      = (n_out > 3'd1) ? conv[1] : 8'd0;
    res.chan2      = (n_out > 3'd2) ? conv[2] : 8'd0;
    res.chan3      = (n_out > 3'd3) ? conv[3] : 8'd0;
    res.byte_count = n_out;
    res.row_end    = r2.row_end;
  end

  assign empty = count == '0;
  assign do_rd = pop && !empty;
  assign pixel = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (v2) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (v2 && !do_rd)
        count <= count + 1'b1;
      else if (do_rd && !v2)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) mem[wr_ptr] <= res;
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    in_use <= (CNT_W+1)'(OUT_DEPTH))
    else $error("output queue overcommitted");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pixel.byte_count >= 3'd1 && pixel.byte_count <= 3'd4))
    else $error("byte count out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && pixel.byte_count == 3'd1) |->
      (pixel.chan1 == 8'd0 && pixel.chan2 == 8'd0 && pixel.chan3 == 8'd0))
    else $error("unused channel not zero");

endmodule

// ----- sv/pixel_format_converter_top.sv -----
// Pixel format converter: source image bytes in, converted pixels out.
// Input channel: push/full with pixel_byte (data byte, image start flag).
//   A byte is taken at an edge with push high and full low; one byte per
//   clock is sustained while full stays low.
// Result channel: empty/pop with pixel (chan0..chan3, byte_count, row_end).
//   The oldest result shows while empty is low and leaves on pop.
// Config: cfg_write with cfg_index/cfg_data writes source format, target
//   format, width in pixels and input row stride. Write only while idle.
// A finished pixel passes the middle queue, luma sum, divide and result queue.
// Throughput: one byte per cycle while full is low, set by the front position
//   counters; the back pipeline takes one pixel per cycle from the 4-entry
//   middle queue while the result queue has room for all in flight.
// Reset: positions, queues and pipeline clear; registers return to A8 to
//   A8, width 1, stride 1.
// Stall: when pop is held low the 4-entry result queue fills, the back stops
//   issuing, the middle queue fills and full rises; nothing is lost.
module pixel_format_converter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pfc_pkg::in_item_t pixel_byte,
  output logic              empty,
  input  logic              pop,
  output pfc_pkg::result_t  pixel,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [18:0]       cfg_data
);
  import pfc_pkg::*;

  cfg_t cfg;
  rec_t q_wr_rec, q_rd_rec;
  logic q_push, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_fmt <= FMT_A8;
      cfg.dst_fmt <= FMT_A8;
      cfg.width   <= 17'd1;
      cfg.stride  <= 19'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_FORMAT: cfg.src_fmt <= cfg_data[2:0];
        REG_TARGET_FORMAT: cfg.dst_fmt <= cfg_data[2:0];
        REG_WIDTH_PIXELS:  cfg.width   <= cfg_data[16:0];
        REG_IN_ROW_BYTES:  cfg.stride  <= cfg_data;
      endcase
    end
  end

  pfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .pixel_byte (pixel_byte),
    .q_full     (full),
    .q_push     (q_push),
    .q_rec      (q_wr_rec)
  );

  pfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .full   (full),
    .empty  (q_empty)
  );

  pfc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rec   (q_rd_rec),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .pixel   (pixel)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int HOLD_CYCLES   = 100;
  localparam int SHOW_LIMIT    = 10;

  // codes above RGBA8888 behave as RGBA8888
  localparam logic [2:0] FMT_ALIAS_LO = 3'd5;
  localparam logic [2:0] FMT_ALIAS_HI = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic        full;
  in_item_t    pixel_byte = '0;
  logic        empty;
  logic        pop        = 1'b0;
  result_t     pixel;
  logic        cfg_write  = 1'b0;
  logic [1:0]  cfg_index  = REG_SOURCE_FORMAT;
  logic [18:0] cfg_data   = '0;

  // converter model: register copies and gather state
  logic [2:0]  src_reg    = FMT_A8;
  logic [2:0]  dst_reg    = FMT_A8;
  logic [16:0] width_reg  = 17'd1;
  logic [18:0] stride_reg = 19'd1;
  int          row_pos    = 0;
  int          pix_cnt    = 0;
  int          chan_pos   = 0;
  logic [23:0] held       = '0;

  in_item_t    byte_q[$];
  result_t     exp_pixels[$];

  int          errors     = 0;
  int          cycles     = 0;
  int          sent       = 0;
  int          received   = 0;
  int          send_gap   = 0;
  int          stall_left = 0;
  int          hold_left  = 0;
  bit          quiet_send = 1'b0;
  bit          quiet_recv = 1'b0;
  int          hold_reqs  = 0;
  int          hold_seen  = 0;
  idle_mode_e  send_mode  = IDLE_NONE;
  idle_mode_e  recv_mode  = IDLE_NONE;

  pixel_format_converter_top u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pixel_byte(pixel_byte),
    .empty(empty),
    .pop(pop),
    .pixel(pixel),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int bytes_per_pixel(input logic [2:0] f);
    case (f)
      FMT_A8, FMT_I8: return 1;
      FMT_IA88:       return 2;
      FMT_RGB888:     return 3;
      default:        return 4;
    endcase
  endfunction

  function automatic int draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      IDLE_HEAVY: return $urandom_range(0, 18);
      default:    return 0;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_format();
    if ($urandom_range(0, 7) == 0)
      return 3'($urandom_range(FMT_ALIAS_LO, FMT_ALIAS_HI));
    return 3'($urandom_range(FMT_A8, FMT_RGBA8888));
  endfunction

  // one accepted byte through the converter; queues a pixel when one completes
  task automatic convert_byte(input in_item_t it);
    logic [2:0] s, d;
    int         w, st, n, y;
    logic [7:0] b [4];
    logic [7:0] o [4];
    result_t    r;
    s  = (src_reg > FMT_RGBA8888) ? FMT_RGBA8888 : src_reg;
    d  = (dst_reg > FMT_RGBA8888) ? FMT_RGBA8888 : dst_reg;
    w  = (width_reg > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(width_reg);
    st = (stride_reg == 0) ? 1 : ((stride_reg > STRIDE_MAX) ? STRIDE_MAX : int'(stride_reg));
    if (it.image_start) begin
      row_pos  = 0;
      pix_cnt  = 0;
      chan_pos = 0;
      held     = '0;
    end
    if (pix_cnt < w) begin
      if (chan_pos + 1 >= bytes_per_pixel(s)) begin
        b[0] = held[7:0];
        b[1] = held[15:8];
        b[2] = held[23:16];
        b[3] = 8'h00;
        b[chan_pos] = it.data_byte;
        // BT.601 weights, rounded
        y = (299 * b[0] + 587 * b[1] + 114 * b[2] + 500) / 1000;
        o = '{default: 8'h00};
        // bytes past the target size are zeroed below, so some cases overfill
        if (s == d || (s <= FMT_I8 && d <= FMT_I8)) begin
          o = b;
        end else begin
          case (s)
            FMT_A8: begin
              if (d == FMT_IA88) begin
                o[0] = ALPHA_OPAQUE;
                o[1] = b[0];
              end else if (d == FMT_RGBA8888) begin
                o[3] = b[0];
              end
            end
            FMT_I8: begin
              o[0] = b[0];
              if (d == FMT_IA88) begin
                o[1] = ALPHA_OPAQUE;
              end else begin
                o[1] = b[0];
                o[2] = b[0];
                o[3] = ALPHA_OPAQUE;
              end
            end
            FMT_IA88: begin
              if (d == FMT_A8) begin
                o[0] = b[1];
              end else begin
                o[0] = b[0];
                o[1] = b[0];
                o[2] = b[0];
                o[3] = b[1];
              end
            end
            FMT_RGB888: begin
              if (d == FMT_I8 || d == FMT_IA88) begin
                o[0] = y[7:0];
                o[1] = ALPHA_OPAQUE;
              end else if (d == FMT_RGBA8888) begin
                o[0] = b[0];
                o[1] = b[1];
                o[2] = b[2];
                o[3] = ALPHA_OPAQUE;
              end
            end
            default: begin
              if (d == FMT_A8) begin
                o[0] = b[3];
              end else if (d == FMT_I8 || d == FMT_IA88) begin
                o[0] = y[7:0];
                o[1] = b[3];
              end else begin
                o[0] = b[0];
                o[1] = b[1];
                o[2] = b[2];
              end
            end
          endcase
        end
        n = bytes_per_pixel(d);
        r.chan0      = o[0];
        r.chan1      = (n > 1) ? o[1] : 8'h00;
        r.chan2      = (n > 2) ? o[2] : 8'h00;
        r.chan3      = (n > 3) ? o[3] : 8'h00;
        r.byte_count = 3'(n);
        r.row_end    = (pix_cnt + 1 == w);
        exp_pixels.push_back(r);
        pix_cnt++;
        chan_pos = 0;
        held     = '0;
      end else begin
        held[8 * chan_pos +: 8] = it.data_byte;
        chan_pos++;
      end
    end
    row_pos++;
    if (row_pos >= st) begin
      row_pos  = 0;
      pix_cnt  = 0;
      chan_pos = 0;
      held     = '0;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        convert_byte(pixel_byte);
        sent++;
        if (sent % 50 == 0) send_mode = idle_mode_e'($urandom_range(0, 2));
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (byte_q.size() != 0) begin
          pixel_byte <= byte_q.pop_front();
          push <= 1'b1;
          send_gap = quiet_send ? 0 : draw_wait(send_mode);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and checker
  always @(posedge clk) begin : pixel_monitor
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        received++;
        if (exp_pixels.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("pixel %0d not expected: %h %h %h %h count %0d end %0d", received,
                     pixel.chan0, pixel.chan1, pixel.chan2, pixel.chan3, pixel.byte_count,
                     pixel.row_end);
        end else begin
          want = exp_pixels.pop_front();
          if (pixel.chan0 !== want.chan0 || pixel.chan1 !== want.chan1 ||
              pixel.chan2 !== want.chan2 || pixel.chan3 !== want.chan3 ||
              pixel.byte_count !== want.byte_count || pixel.row_end !== want.row_end) begin
            errors++;
            if (errors <= SHOW_LIMIT)
              $display("pixel %0d: exp %h %h %h %h count %0d end %0d, got %h %h %h %h count %0d end %0d",
                       received, want.chan0, want.chan1, want.chan2, want.chan3,
                       want.byte_count, want.row_end, pixel.chan0, pixel.chan1, pixel.chan2,
                       pixel.chan3, pixel.byte_count, pixel.row_end);
          end
        end
        stall_left = quiet_recv ? 0 : draw_wait(recv_mode);
        if (received % 50 == 0) recv_mode = idle_mode_e'($urandom_range(0, 2));
      end
      if (hold_seen != hold_reqs) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] data, input logic start);
    in_item_t it;
    it.data_byte   = data;
    it.image_start = start;
    byte_q.push_back(it);
  endtask

  // all items sent, all pixels back, then room for anything still in flight
  task automatic wait_drained();
    do @(negedge clk); while (byte_q.size() != 0 || push || exp_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // unused high bits of the narrow registers get random fill
  task automatic configure(input logic [2:0] src, input logic [2:0] dst,
                           input logic [16:0] width, input logic [18:0] stride);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SOURCE_FORMAT;
    cfg_data  <= {16'($urandom), src};
    src_reg = src;
    @(posedge clk);
    cfg_index <= REG_TARGET_FORMAT;
    cfg_data  <= {16'($urandom), dst};
    dst_reg = dst;
    @(posedge clk);
    cfg_index <= REG_WIDTH_PIXELS;
    cfg_data  <= {2'($urandom), width};
    width_reg = width;
    @(posedge clk);
    cfg_index <= REG_IN_ROW_BYTES;
    cfg_data  <= stride;
    stride_reg = stride;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int          k, i, sel, row_len, eff, total, rand_items;
    logic [2:0]  src, dst;
    logic [16:0] width;
    logic [18:0] stride;
    bit          lead;
    rand_items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: A8 straight through, one-byte rows
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hA5, 1'b1);
    wait_drained();

    // luma of white and of black
    configure(FMT_RGB888, FMT_I8, 17'd2, 19'd6);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    wait_drained();

    // zero width converts nothing, zero stride acts as one
    configure(FMT_I8, FMT_ALIAS_HI, 17'd0, 19'd0);
    add_byte(8'h5A, 1'b1);
    add_byte(8'hC3, 1'b0);
    wait_drained();

    // aliased source code with a stride shorter than the pixels of a row
    configure(FMT_ALIAS_LO, FMT_A8, 17'd3, 19'd5);
    for (k = 0; k < 7; k++) add_byte(8'(8'h10 * k + 1), k == 0);
    wait_drained();

    // image start in mid pixel drops what was gathered
    configure(FMT_IA88, FMT_RGBA8888, 17'd2, 19'd4);
    add_byte(8'h11, 1'b1);
    add_byte(8'h22, 1'b1);
    add_byte(8'h33, 1'b0);
    wait_drained();

    // receiver holds off while bytes keep coming, so the input backs up
    configure(FMT_I8, FMT_RGBA8888, 17'd40, 19'd40);
    quiet_send = 1'b1;
    hold_reqs++;
    for (k = 0; k < 40; k++) add_byte(pick_byte(), k == 0);
    wait_drained();
    quiet_send = 1'b0;

    // random rows; the first 25 settings walk every format pair
    k = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (k < 25) begin
        src = 3'(k % 5);
        dst = 3'(k / 5);
      end else begin
        src = pick_format();
        dst = pick_format();
      end
      width   = ($urandom_range(0, 11) == 0) ? 17'd0 : 17'($urandom_range(1, 6));
      row_len = width * bytes_per_pixel(src);
      sel     = $urandom_range(0, 9);
      if (sel < 6)
        stride = 19'(row_len + $urandom_range(0, 3));
      else if (sel < 8 && row_len > 1)
        stride = 19'($urandom_range(1, row_len - 1));
      else if (sel == 8)
        stride = 19'd0;
      else
        stride = 19'(row_len);
      configure(src, dst, width, stride);
      eff   = (stride == 0) ? 1 : int'(stride);
      total = eff * $urandom_range(2, 6);
      // some images are cut short, leaving a partial pixel behind
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      lead = ($urandom_range(0, 3) != 0);
      for (i = 0; i < total; i++)
        add_byte(pick_byte(), (i == 0 && lead) || $urandom_range(0, 39) == 0);
      rand_items += total;
      wait_drained();
      k++;
    end

    // width and stride right at their limits
    configure(FMT_RGB888, FMT_RGBA8888, 17'(MAX_ROW_PIXELS), 19'(STRIDE_MAX));
    for (k = 0; k < 12; k++) add_byte(pick_byte(), k == 0);
    wait_drained();

    // all-ones width and stride saturate; no row end in the first pixels
    configure(FMT_A8, FMT_I8, 17'h1FFFF, 19'h7FFFF);
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    for (k = 0; k < 16; k++) add_byte(8'($urandom), k == 0);
    wait_drained();

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pfc_pkg.sv
sv/pfc_front.sv
sv/pfc_queue.sv
sv/pfc_back.sv
sv/pixel_format_converter_top.sv
verif/testbench.sv
